// ----- rtl/core/sdp_pkg.sv -----
// Shared constants and controller/datapath interface types for the sparse dot product.
package sdp_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int ID_W  = 31;
  localparam int VAL_W = 32;
  localparam int ACC_W = 64;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture the accepted item, rewind the scan
    logic rd_en;      // read table entry at scan index
    logic addr_inc;   // step scan index
    logic wr_hit;     // overwrite value at scan index
    logic wr_new;     // append entry at fill count
    logic set_ovf;    // dropped load
    logic mul;        // register product of item and stored value
    logic acc;        // saturating accumulate
    logic emit;       // present result, clear the sum
    logic clear_all;  // empty table, clear flags and sum
  } sdp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_load;
    logic is_query;
    logic is_clear;
    logic last;
    logic match;       // registered table entry matches item id
    logic scan_last;   // scan index is the final filled slot
    logic table_empty;
    logic table_full;
  } sdp_status_t;

endpackage

// ----- rtl/core/sparse_dot_product_top.sv -----
// Sparse vector dot product: one loaded vector in a table, queried by a streamed vector.
// Items are taken one at a time: an item is transferred on a clock edge with start high and
// busy low, and busy stays high until the item is finished. The table is scanned one entry at
// a time (read, then compare); a load or query hit ends the scan, a miss scans every filled
// slot, a query hit adds the multiply and the accumulate steps, and a final query adds the
// result step. A clear finishes in the decode step after the transfer.
// A result appears for one cycle with done high and cannot be held off by the receiver; it
// follows the final query item of a vector and busy drops in the same cycle.
module sparse_dot_product_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          command,
  input  logic [sdp_pkg::ID_W-1:0]            feature_id,
  input  logic signed [sdp_pkg::VAL_W-1:0]    feature_value,
  input  logic                                last_entry,
  output logic                                done,
  output logic signed [sdp_pkg::ACC_W-1:0]    dot_value,
  output logic                                table_overflow,
  output logic                                sum_saturated
);
  import sdp_pkg::*;

  sdp_cmd_t    cmd;
  sdp_status_t status;

  sdp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  sdp_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .command        (command),
    .feature_id     (feature_id),
    .feature_value  (feature_value),
    .last_entry     (last_entry),
    .cmd            (cmd),
    .status         (status),
    .done           (done),
    .dot_value      (dot_value),
    .table_overflow (table_overflow),
    .sum_saturated  (sum_saturated)
  );

endmodule

// ----- rtl/core/sdp_datapath.sv -----
// Table memory, scan counter, multiplier and saturating accumulator.
module sdp_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [1:0]                          command,
  input  logic [sdp_pkg::ID_W-1:0]            feature_id,
  input  logic signed [sdp_pkg::VAL_W-1:0]    feature_value,
  input  logic                                last_entry,
  input  sdp_pkg::sdp_cmd_t                   cmd,
  output sdp_pkg::sdp_status_t                status,
  output logic                                done,
  output logic signed [sdp_pkg::ACC_W-1:0]    dot_value,
  output logic                                table_overflow,
  output logic                                sum_saturated
);
  import sdp_pkg::*;

  logic [ID_W+VAL_W-1:0]    mem [TABLE_ENTRIES];

  logic [1:0]               cmd_r;
  logic [ID_W-1:0]          id_r;
  logic signed [VAL_W-1:0]  val_r;
  logic                     last_r;
  logic [IDX_W-1:0]         idx;
  logic [CNT_W-1:0]         count;
  logic [ID_W-1:0]          rd_id;
  logic signed [VAL_W-1:0]  rd_val;
  logic signed [ACC_W-1:0]  prod;
  logic signed [ACC_W-1:0]  accum;
  logic                     ovf;
  logic                     sat;
  logic signed [ACC_W:0]    sum;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;

  assign wr_en   = cmd.wr_hit | cmd.wr_new;
  assign wr_addr = cmd.wr_new ? count[IDX_W-1:0] : idx;

  // table store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {id_r, val_r};
    end
    if (cmd.rd_en) begin
      {rd_id, rd_val} <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r  <= command;
      id_r   <= feature_id;
      val_r  <= feature_value;
      last_r <= last_entry;
    end
    if (cmd.mul) begin
      // sign-extended 32 x 32 product
      prod <= ACC_W'(val_r) * ACC_W'(rd_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.latch) begin
      idx <= '0;
    end else if (cmd.addr_inc) begin
      idx <= idx + IDX_W'(1);
    end
  end

  assign sum = {accum[ACC_W-1], accum} + {prod[ACC_W-1], prod};

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      count <= '0;
      accum <= '0;
      ovf   <= 1'b0;
      sat   <= 1'b0;
    end else begin
      if (cmd.wr_new) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.acc) begin
        if (sum[ACC_W] != sum[ACC_W-1]) begin
          // clamp to the bound on the side of the overflow
          accum <= sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
          sat   <= 1'b1;
        end else begin
          accum <= sum[ACC_W-1:0];
        end
      end else if (cmd.emit) begin
        accum <= '0;
        sat   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
    if (cmd.emit) begin
      dot_value      <= accum;
      table_overflow <= ovf;
      sum_saturated  <= sat;
    end
  end

  always_comb begin
    status.is_load     = (cmd_r == CMD_LOAD);
    status.is_query    = (cmd_r == CMD_QUERY);
    status.is_clear    = (cmd_r == CMD_CLEAR);
    status.last        = last_r;
    status.match       = (rd_id == id_r);
    status.scan_last   = ((CNT_W'(idx) + CNT_W'(1)) == count);
    status.table_empty = (count == '0);
    status.table_full  = (count == CNT_W'(TABLE_ENTRIES));
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    done |-> (accum == '0) && !sat)
    else $error("sum not cleared after result transfer");

  a_new_only_free: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_new |-> !status.table_full)
    else $error("append into full table");

endmodule

// ----- rtl/core/sdp_ctrl.sv -----
// Sequencer for load, query and clear items: table scan and accumulate steps.
module sdp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  sdp_pkg::sdp_status_t  status,
  output sdp_pkg::sdp_cmd_t     cmd
);
  import sdp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_READ   = 8'b0000_0100,
    S_CMP    = 8'b0000_1000,
    S_MISS   = 8'b0001_0000,
    S_MUL    = 8'b0010_0000,
    S_ACC    = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (status.is_clear) begin
          cmd.clear_all = 1'b1;
          state_next    = S_IDLE;
        end else if (status.is_load || status.is_query) begin
          state_next = status.table_empty ? S_MISS : S_READ;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        // ids in the table are unique, so the first match is the only one
        priority if (status.match) begin
          if (status.is_load) begin
            cmd.wr_hit = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_MUL;
          end
        end else if (status.scan_last) begin
          state_next = S_MISS;
        end else begin
          cmd.addr_inc = 1'b1;
          state_next   = S_READ;
        end
      end
      S_MISS: begin
        if (status.is_load) begin
          cmd.set_ovf = status.table_full;
          cmd.wr_new  = !status.table_full;
          state_next  = S_IDLE;
        end else begin
          state_next = status.last ? S_EMIT : S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_emit_query_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (status.is_query && status.last))
    else $error("result for an item that is not a final query");

  a_write_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_hit && cmd.wr_new) && !(cmd.acc && cmd.emit))
    else $error("conflicting datapath commands");

endmodule
